// ===== sv/kdlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types, codes and the key legend for the keypad debounce block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    localparam int ROW_COUNT_DEF = 4;
    localparam int COL_COUNT_DEF = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;

    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_LONG    = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]  scan_row;
        logic [1:0]  scan_col;
        logic        contact_closed;
        logic [31:0] now_ms;
    } scan_req_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [1:0] event_row;
        logic [1:0] event_col;
        logic [6:0] legend_char;
    } key_event_t;

    // one entry of the per-key store
    typedef struct packed {
        phase_t      phase;
        logic [31:0] press_start;
        logic [31:0] last_change;
        logic        confirmed;
        logic        long_done;
    } key_entry_t;

    function automatic logic [6:0] key_legend(input logic [1:0] row, input logic [1:0] col);
        logic [6:0] ch;
        case ({row, col})
            4'h0:    ch = 7'h31; // '1'
            4'h1:    ch = 7'h32; // '2'
            4'h2:    ch = 7'h33; // '3'
            4'h3:    ch = 7'h41; // 'A'
            4'h4:    ch = 7'h34; // '4'
            4'h5:    ch = 7'h35; // '5'
            4'h6:    ch = 7'h36; // '6'
            4'h7:    ch = 7'h42; // 'B'
            4'h8:    ch = 7'h37; // '7'
            4'h9:    ch = 7'h38; // '8'
            4'hA:    ch = 7'h39; // '9'
            4'hB:    ch = 7'h43; // 'C'
            4'hC:    ch = 7'h2A; // '*'
            4'hD:    ch = 7'h30; // '0'
            4'hE:    ch = 7'h23; // '#'
            default: ch = 7'h44; // 'D'
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/keypad_debounce_long_press.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_debounce_long_press
// Per-key debounce and long-press detection over a key-state memory.
//
//   channel   dir   handshake            payload
//   s_        in    s_valid / s_ready    s_data  (scan_req_t)
//   m_        out   m_valid / m_ready    m_data  (key_event_t)
//   cfg_      in    cfg_we               cfg_index, cfg_wdata
//
// Each request has a read step, which fetches the key's entry from the state
// memory, then an update step, which updates it, writes it back and loads the result register.
// The update step waits while an earlier result is still held at m_.
// Reset (aresetn low, synchronous) marks every key entry idle at once
// through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keypad_debounce_long_press #(
    parameter int ROW_COUNT = kdlp_pkg::ROW_COUNT_DEF,
    parameter int COL_COUNT = kdlp_pkg::COL_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  kdlp_pkg::scan_req_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output kdlp_pkg::key_event_t            m_data,
    input  logic                            cfg_we,
    input  logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import kdlp_pkg::*;

    localparam int KEY_TOTAL = ROW_COUNT * COL_COUNT;
    localparam int KEY_W     = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [15:0]     debounce_reg;
    logic [15:0]     long_press_reg;
    scan_req_t       req_reg;
    logic            in_range_reg;
    logic [KEY_W-1:0] addr_reg;
    key_entry_t      rd_ent_reg;
    logic            rd_valid_reg;
    logic [KEY_TOTAL-1:0] key_valid_reg;
    key_entry_t      key_mem [KEY_TOTAL];
    logic            m_valid_reg;
    key_event_t      m_data_reg;

    logic            s_fire;
    logic            s_in_range;
    logic [KEY_W-1:0] s_key;
    logic            out_free;
    logic            exec_fire;
    key_entry_t      ent;
    key_entry_t      wr_ent;
    logic            emit;
    logic [1:0]      emit_kind;
    logic [31:0]     since_change;
    logic [31:0]     since_press;
    logic            db_done;
    logic            lp_done;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign s_in_range = (32'(s_data.scan_row) < ROW_COUNT) && (32'(s_data.scan_col) < COL_COUNT);
    assign s_key = s_in_range
        ? KEY_W'(32'(s_data.scan_row) * COL_COUNT + 32'(s_data.scan_col))
        : '0;

    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // an entry never written since reset reads as idle with flags clear
    always_comb begin
        ent = rd_ent_reg;
        if (!rd_valid_reg) begin
            ent.phase     = PH_IDLE;
            ent.confirmed = 1'b0;
            ent.long_done = 1'b0;
        end
    end

    assign since_change = req_reg.now_ms - ent.last_change;
    assign since_press  = req_reg.now_ms - ent.press_start;
    assign db_done = since_change >= {16'd0, debounce_reg};
    assign lp_done = since_press >= {16'd0, long_press_reg};

    always_comb begin
        wr_ent    = ent;
        emit      = 1'b0;
        emit_kind = EV_PRESS;
        if (req_reg.contact_closed) begin
            if (ent.phase == PH_IDLE) begin
                wr_ent.phase       = PH_PRESSED;
                wr_ent.press_start = req_reg.now_ms;
                wr_ent.last_change = req_reg.now_ms;
                wr_ent.confirmed   = 1'b0;
                wr_ent.long_done   = 1'b0;
            end else if (ent.phase == PH_PRESSED && !ent.confirmed) begin
                if (db_done) begin
                    wr_ent.confirmed = 1'b1;
                    emit             = 1'b1;
                    emit_kind        = EV_PRESS;
                end
            end else if (ent.confirmed && !ent.long_done) begin
                // also reached while released: release timing keeps running
                if (lp_done) begin
                    wr_ent.long_done = 1'b1;
                    emit             = 1'b1;
                    emit_kind        = EV_LONG;
                end
            end
        end else begin
            if (ent.phase == PH_PRESSED && ent.confirmed) begin
                wr_ent.phase       = PH_RELEASED;
                wr_ent.last_change = req_reg.now_ms;
            end else if (ent.phase == PH_RELEASED) begin
                if (db_done) begin
                    wr_ent.phase     = PH_IDLE;
                    wr_ent.confirmed = 1'b0;
                    emit             = 1'b1;
                    emit_kind        = EV_RELEASE;
                end
            end else if (ent.phase == PH_PRESSED) begin
                // bounce before debounce: back to idle
                wr_ent.phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
            key_valid_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                    CFG_LONG_PRESS: long_press_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (exec_fire && in_range_reg) key_valid_reg[addr_reg] <= 1'b1;
            if (exec_fire && in_range_reg && emit) m_valid_reg <= 1'b1;
            else if (m_ready)                      m_valid_reg <= 1'b0;
        end
    end

    // request latch, state memory and result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg      <= s_data;
            in_range_reg <= s_in_range;
            addr_reg     <= s_key;
            rd_ent_reg   <= key_mem[s_key];
            rd_valid_reg <= key_valid_reg[s_key];
        end
        if (exec_fire && in_range_reg) key_mem[addr_reg] <= wr_ent;
        if (exec_fire && in_range_reg && emit) begin
            m_data_reg.event_kind  <= emit_kind;
            m_data_reg.event_row   <= req_reg.scan_row;
            m_data_reg.event_col   <= req_reg.scan_col;
            m_data_reg.legend_char <= key_legend(req_reg.scan_row, req_reg.scan_col);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
